// ===== rtl/rle_sprite_palette_decoder_defines.svh =====
// Assertion macros used by the sprite decoder RTL.
`ifndef RLE_SPRITE_PALETTE_DECODER_DEFINES_SVH
`define RLE_SPRITE_PALETTE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsp_pkg.sv =====
// Shared types and constants for the run-length sprite decoder.
package rsp_pkg;

  localparam int MAX_SIDE  = 1024;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int COLOR_W   = 24;
  localparam int ADDR_W    = 20;
  localparam int SIDE_W    = 11;
  localparam int LEN_W     = 22;
  localparam int COMP_W    = 6;

  typedef enum logic [1:0] {
    CMD_PAL   = 2'd0,
    CMD_START = 2'd1,
    CMD_BODY  = 2'd2,
    CMD_NOP   = 2'd3
  } rsp_cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        byte_value;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [LEN_W-1:0]  body_length;
  } rsp_in_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               done_res;
    logic               overrun;
  } rsp_out_t;

  // Palette port request from the decoder to the RAM.
  typedef struct packed {
    logic               we;
    logic [PAL_AW-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [PAL_AW-1:0]  raddr;
  } rsp_pal_req_t;

endpackage

// ===== rtl/rsp_palette_ram.sv =====
// Palette memory: one write port, one read port, registered read data.
module rsp_palette_ram
  import rsp_pkg::*;
(
  input  logic               clk,
  input  rsp_pal_req_t       req,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [PAL_DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Holds its value between reads so a stalled result keeps its color.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rle_sprite_palette_decoder.sv =====
// Top level of the run-length sprite decoder with palette lookup.
//
// Input channel (in_valid / in_stall / in_data) carries one request per cycle
// while in_stall is low: palette writes, a picture start with width, height
// and body length, and the run-length body bytes. Every accepted request yields
// exactly one result on the output channel (out_valid / out_stall / out_data):
// a pixel write with framebuffer address and palette color, or an empty result
// carrying the done and overrun flags.
// Each result is registered with its color read from the registered-read
// palette RAM, and is shown unless an older result waits in the skid register.
// Throughput is one request per cycle while the skid register is empty; the
// palette RAM read port and the address multiplier each serve one request per
// cycle. When the receiver stalls, the pending result moves into a skid
// register and one more request is still taken; in_stall rises only while the
// skid register is occupied or rst_n is low. cfg_we / cfg_wdata set the rotate
// bit (rotated addresses); write it only while no request is in flight.
// Reset (rst_n low, synchronous) holds in_stall high and clears the decode state,
// the rotate bit and both result stages. The palette has no reset; entries read
// before written return undefined colors.
module rle_sprite_palette_decoder
  import rsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rsp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rsp_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

`include "rle_sprite_palette_decoder_defines.svh"

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ROWCNT,
    PH_SKIP,
    PH_SOLID,
    PH_PIXEL,
    PH_DONE
  } phase_t;

  localparam int RBU_W = 9;
  localparam int CNT_W = 8;

  phase_t            phase_r, phase_nxt;
  logic [SIDE_W-1:0] row_index_r, row_index_nxt;
  logic [SIDE_W-1:0] column_r, column_nxt;
  logic [RBU_W-1:0]  row_bytes_used_r, row_bytes_used_nxt;
  logic [CNT_W-1:0]  row_count_r, row_count_nxt;
  logic [LEN_W-1:0]  bytes_used_r, bytes_used_nxt;
  logic [CNT_W-1:0]  run_left_r, run_left_nxt;
  logic [SIDE_W-1:0] pic_width_r, pic_width_nxt;
  logic [SIDE_W-1:0] pic_height_r, pic_height_nxt;
  logic [LEN_W-1:0]  pic_length_r, pic_length_nxt;
  logic              rotate_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_wv_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_done_r;
  logic              s1_ovr_r;
  logic              skid_full_r, skid_full_nxt;
  rsp_out_t          skid_r;
  rsp_out_t          s1_out;

  logic               in_accept;
  logic               out_fire;
  logic               decoding;
  logic               wv0, ovr0;
  rsp_pal_req_t       pal_req;
  logic [COLOR_W-1:0] pal_rdata;

  logic [SIDE_W-1:0]   w_clip, h_clip;
  logic [SIDE_W-1:0]   ri_inc, col_inc, col_skip;
  logic [SIDE_W:0]     col_sum;
  logic [RBU_W-1:0]    rbu_inc;
  logic [LEN_W-1:0]    bu_inc;
  logic [LEN_W:0]      bu_next_plus;
  phase_t              er_phase;
  logic                rbu_full;
  logic [SIDE_W-1:0]   mul_a, mul_b, offs;
  logic [2*SIDE_W-1:0] prod, addr_full;
  logic [7:0]          b;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = skid_full_r || !rst_n;
  assign b         = in_data.byte_value;

  assign w_clip = (in_data.width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : in_data.width;
  assign h_clip = (in_data.height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : in_data.height;

  // Saturating counters
  assign ri_inc  = (row_index_r == '1) ? row_index_r : row_index_r + 1'b1;
  assign col_inc = (column_r == '1) ? column_r : column_r + 1'b1;
  assign rbu_inc = (row_bytes_used_r == '1) ? row_bytes_used_r : row_bytes_used_r + 1'b1;
  assign bu_inc  = (bytes_used_r == '1) ? bytes_used_r : bytes_used_r + 1'b1;
  assign col_sum  = {1'b0, column_r} + {{(SIDE_W-7){1'b0}}, b};
  assign col_skip = col_sum[SIDE_W] ? '1 : col_sum[SIDE_W-1:0];

  // Row end: last row, or a counted row with at most one body byte left
  assign bu_next_plus = {1'b0, bu_inc} + 1'b1;
  assign er_phase = (ri_inc >= pic_height_r) ? PH_DONE :
                    ((row_count_r != '0) && (bu_next_plus >= {1'b0, pic_length_r})) ?
                    PH_DONE : PH_ROWCNT;
  assign rbu_full = rbu_inc >= {1'b0, row_count_r};

  // One shared multiplier for both address forms
  assign mul_a     = rotate_r ? column_r : row_index_r;
  assign mul_b     = rotate_r ? pic_height_r : pic_width_r;
  assign offs      = rotate_r ? (pic_height_r - 1'b1 - row_index_r) : column_r;
  assign prod      = mul_a * mul_b;
  assign addr_full = prod + {{SIDE_W{1'b0}}, offs};

  always_comb begin
    phase_nxt          = phase_r;
    row_index_nxt      = row_index_r;
    column_nxt         = column_r;
    row_bytes_used_nxt = row_bytes_used_r;
    row_count_nxt      = row_count_r;
    bytes_used_nxt     = bytes_used_r;
    run_left_nxt       = run_left_r;
    pic_width_nxt      = pic_width_r;
    pic_height_nxt     = pic_height_r;
    pic_length_nxt     = pic_length_r;
    wv0                = 1'b0;
    ovr0               = 1'b0;
    pal_req.we         = 1'b0;
    pal_req.waddr      = b;
    pal_req.wdata      = {in_data.red, 2'b00, in_data.green, 2'b00, in_data.blue, 2'b00};
    pal_req.re         = 1'b0;
    pal_req.raddr      = b;

    case (in_data.cmd)
      CMD_PAL: begin
        pal_req.we = in_accept;
      end
      CMD_START: begin
        pic_width_nxt      = w_clip;
        pic_height_nxt     = h_clip;
        pic_length_nxt     = in_data.body_length;
        row_index_nxt      = '0;
        column_nxt         = '0;
        row_bytes_used_nxt = '0;
        row_count_nxt      = '0;
        bytes_used_nxt     = '0;
        run_left_nxt       = '0;
        phase_nxt          = (h_clip == '0) ? PH_DONE : PH_ROWCNT;
      end
      CMD_BODY: begin
        if (phase_r != PH_IDLE && phase_r != PH_DONE) begin
          bytes_used_nxt     = bu_inc;
          row_bytes_used_nxt = rbu_inc;
          case (phase_r)
            PH_ROWCNT: begin
              row_count_nxt      = b;
              row_bytes_used_nxt = RBU_W'(1);
              column_nxt         = '0;
              if (b == '0) begin
                row_index_nxt = ri_inc;
                phase_nxt     = (ri_inc >= pic_height_r) ? PH_DONE : PH_ROWCNT;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_SKIP: begin
              column_nxt = col_skip;
              if (col_skip >= pic_width_r) begin
                row_index_nxt = ri_inc;
                phase_nxt     = er_phase;
              end else begin
                phase_nxt = PH_SOLID;
              end
            end
            PH_SOLID: begin
              run_left_nxt = b;
              if (b != '0) begin
                phase_nxt = PH_PIXEL;
              end else if (column_r >= pic_width_r || rbu_full) begin
                row_index_nxt = ri_inc;
                phase_nxt     = er_phase;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_PIXEL: begin
              if (column_r < pic_width_r) begin
                wv0        = 1'b1;
                pal_req.re = in_accept;
              end else begin
                ovr0 = 1'b1;
              end
              column_nxt   = col_inc;
              run_left_nxt = run_left_r - 1'b1;
              if (run_left_r == CNT_W'(1)) begin
                if (col_inc >= pic_width_r || rbu_full) begin
                  row_index_nxt = ri_inc;
                  phase_nxt     = er_phase;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Result stage and skid register
  always_comb begin
    s1_out.write_valid = s1_wv_r;
    s1_out.address     = s1_addr_r;
    s1_out.color       = s1_wv_r ? pal_rdata : '0;
    s1_out.done_res    = s1_done_r;
    s1_out.overrun     = s1_ovr_r;

    if (skid_full_r) begin
      skid_full_nxt = out_stall;
      s1_valid_nxt  = s1_valid_r;
    end else begin
      skid_full_nxt = s1_valid_r && out_stall;
      s1_valid_nxt  = in_accept;
    end
  end

  assign out_valid = skid_full_r || s1_valid_r;
  assign out_data  = skid_full_r ? skid_r : s1_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      row_index_r      <= '0;
      column_r         <= '0;
      row_bytes_used_r <= '0;
      row_count_r      <= '0;
      bytes_used_r     <= '0;
      run_left_r       <= '0;
      pic_width_r      <= '0;
      pic_height_r     <= '0;
      pic_length_r     <= '0;
      rotate_r         <= 1'b0;
      s1_valid_r       <= 1'b0;
      skid_full_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r          <= phase_nxt;
        row_index_r      <= row_index_nxt;
        column_r         <= column_nxt;
        row_bytes_used_r <= row_bytes_used_nxt;
        row_count_r      <= row_count_nxt;
        bytes_used_r     <= bytes_used_nxt;
        run_left_r       <= run_left_nxt;
        pic_width_r      <= pic_width_nxt;
        pic_height_r     <= pic_height_nxt;
        pic_length_r     <= pic_length_nxt;
      end
      if (cfg_we) begin
        rotate_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r && s1_valid_r && out_stall) begin
      skid_r <= s1_out;
    end
    if (in_accept) begin
      s1_wv_r   <= wv0;
      s1_addr_r <= wv0 ? addr_full[ADDR_W-1:0] : '0;
      s1_done_r <= (phase_nxt == PH_DONE);
      s1_ovr_r  <= ovr0;
    end
  end

  rsp_palette_ram u_palette (
    .clk   (clk),
    .req   (pal_req),
    .rdata (pal_rdata)
  );

  assign decoding = phase_r inside {PH_ROWCNT, PH_SKIP, PH_SOLID, PH_PIXEL};
  assign out_fire = out_valid && !out_stall;

  `RSP_ASSERT_NOW(a_pixel_run_nonzero, phase_r == PH_PIXEL, run_left_r != '0, "empty pixel run")
  `RSP_ASSERT_NOW(a_row_in_picture, decoding, row_index_r < pic_height_r, "row past picture")
  `RSP_ASSERT_NEXT(a_drain_empty, out_fire && !skid_full_r && !in_accept, !out_valid, "stray result")

endmodule
